// File: rtl/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the byte stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int QueueDepth = 4;

    typedef enum logic [0:0] {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LengthAt = 6'd56;

    localparam logic [31:0] InitH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] sm_s0(input logic [31:0] x);
        sm_s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sm_s1(input logic [31:0] x);
        sm_s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: rtl/sha_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA command queue
// Short queue between the input side and the hashing engine.
// ----------------------------------------------------------------------------
module sha_cmd_fifo
    import sha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);
    localparam int AddrW = $clog2(QueueDepth);

    t_cmd             r_mem [QueueDepth];
    logic [AddrW-1:0] r_wr;
    logic [AddrW-1:0] r_rd;
    logic [AddrW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (AddrW+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AddrW+1)'(do_push) - (AddrW+1)'(do_pop);
        end
    end

endmodule

// File: rtl/sha_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA engine
// Buffers bytes, pads, runs 64 rounds per block and emits digest chunks.
// ----------------------------------------------------------------------------
module sha_engine
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [63:0] o_digest_chunk,
    output logic [1:0]  o_chunk_index,
    output logic        o_last_chunk
);
    t_state       r_state, n_state;
    logic [31:0]  r_buf [16];  // block buffer, big-endian words
    logic [31:0]  r_h   [8];
    logic [31:0]  r_v   [8];
    logic [31:0]  r_w   [16];
    logic [5:0]   r_fill;
    logic [63:0]  r_total;
    logic [5:0]   r_round;
    logic         r_final;   // compression belongs to a finish item
    logic         r_second;  // length block still to come
    logic [1:0]   r_chunk;

    logic [31:0] t1, t2, w_cur, w_new;
    logic [63:0] bits;
    logic        byte_go, fin_go;

    assign bits  = {r_total[60:0], 3'b000};
    assign w_cur = r_w[0];
    assign w_new = r_w[0] + sm_s0(r_w[1]) + r_w[9] + sm_s1(r_w[14]);
    assign t1 = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + RoundK[r_round] + w_cur;
    assign t2 = big_s0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2])
              ^ (r_v[1] & r_v[2]));

    assign byte_go = (r_state == ST_IDLE) && i_cmd_valid && (i_cmd.op == OP_ABSORB);
    assign fin_go  = (r_state == ST_IDLE) && i_cmd_valid && (i_cmd.op == OP_FINISH);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (byte_go && (r_fill == 6'd63)) begin
                    n_state = ST_ROUND;
                end else if (fin_go) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD:   n_state = ST_ROUND;
            ST_ROUND: begin
                if (r_round == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                priority if (r_second) begin
                    n_state = ST_PAD;
                end else if (r_final) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_pop && (r_chunk == 2'd3)) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop      = (r_state == ST_IDLE) && i_cmd_valid;
        o_empty        = (r_state != ST_EMIT);
        o_digest_chunk = {r_h[{r_chunk, 1'b0}], r_h[{r_chunk, 1'b1}]};
        o_chunk_index  = r_chunk;
        o_last_chunk   = (r_chunk == 2'd3);
    end

    // block buffer, message schedule and working variables
    always_ff @(posedge i_clk) begin
        if (byte_go) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_cmd.data_byte;
        end
        if (fin_go) begin
            // 0x80 after the last byte, zeros up to the end of the block
            for (int i = 0; i < 16; i++) begin
                if (4'(i) > r_fill[5:2]) begin
                    r_buf[i] <= '0;
                end else if (4'(i) == r_fill[5:2]) begin
                    for (int b = 0; b < 4; b++) begin
                        if (2'(b) == r_fill[1:0]) begin
                            r_buf[i][8*(3-b) +: 8] <= PadByte;
                        end else if (2'(b) > r_fill[1:0]) begin
                            r_buf[i][8*(3-b) +: 8] <= 8'h00;
                        end
                    end
                end
            end
        end
        if (r_state == ST_PAD) begin
            for (int i = 0; i < 14; i++) begin
                r_w[i] <= r_buf[i];
            end
            r_w[14] <= r_second ? r_buf[14] : bits[63:32];
            r_w[15] <= r_second ? r_buf[15] : bits[31:0];
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (r_state == ST_IDLE && byte_go && r_fill == 6'd63) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_buf[i];
            end
            r_w[15] <= {r_buf[15][31:8], i_cmd.data_byte};
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (r_state == ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (r_state == ST_ADD && r_second) begin
            // second block carries only zeros and the length
            for (int i = 0; i < 16; i++) begin
                r_buf[i] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_total  <= '0;
            r_round  <= '0;
            r_final  <= 1'b0;
            r_second <= 1'b0;
            r_chunk  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= InitH[i];
            end
        end else begin
            r_state <= n_state;
            if (byte_go) begin
                r_fill  <= r_fill + 1'b1;
                r_total <= r_total + 64'd1;
            end
            if (fin_go) begin
                r_final  <= 1'b1;
                // 0x80 plus the length no longer fit in this block
                r_second <= (r_fill >= LengthAt);
            end
            if (r_state == ST_ROUND) begin
                r_round <= r_round + 1'b1;
            end
            if (r_state == ST_ADD) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
                r_second <= 1'b0;
            end
            if (r_state == ST_EMIT && i_pop) begin
                r_chunk <= r_chunk + 1'b1;
                if (r_chunk == 2'd3) begin
                    r_final <= 1'b0;
                    r_fill  <= '0;
                    r_total <= '0;
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= InitH[i];
                    end
                end
            end
        end
    end

endmodule

// File: rtl/sha256_byte_stream_hasher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and emits the digest as four 64-bit chunks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_push / o_full. op 0 absorbs i_data_byte, op 1 finishes
//   the message. Items land in a four-entry queue, then in the engine.
//   Result channel: o_empty / i_pop. A finish gives four chunks, index 0 to 3,
//   o_last_chunk marking the final one; absorbs give no result.
//   The engine takes an absorb while idle; the 64th byte of a block runs
//   the round loop (one round per cycle, then the add) before the next item.
//   A finish runs the padding block, and a second one when it is needed,
//   before the first chunk shows; the engine holds until all four are popped.
//   A stalled receiver backs up the engine, then the queue, then o_full.
//   Reset (synchronous, i_rst_n low) empties the queue and loads the initial
//   hash values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [63:0] o_digest_chunk,
    output logic [1:0]  o_chunk_index,
    output logic        o_last_chunk
);
    t_cmd in_cmd, q_cmd;
    logic q_empty, q_pop;

    assign in_cmd.op        = t_op'(i_op);
    assign in_cmd.data_byte = i_data_byte;

    sha_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_cmd   (in_cmd),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    sha_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!q_empty),
        .i_cmd          (q_cmd),
        .o_cmd_pop      (q_pop),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_digest_chunk (o_digest_chunk),
        .o_chunk_index  (o_chunk_index),
        .o_last_chunk   (o_last_chunk)
    );

endmodule

// File: rtl/sha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA port checker
// Port-level checks on chunk ordering and stall hold, bound to the hasher core.
// ----------------------------------------------------------------------------
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic [63:0] o_digest_chunk,
    input logic [1:0]  o_chunk_index,
    input logic        o_last_chunk
);
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_last_chunk == (o_chunk_index == 2'd3)))
        else $error("last flag mismatch");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last_chunk) |=>
            (!o_empty && o_chunk_index == $past(o_chunk_index) + 2'd1))
        else $error("chunk index did not advance");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_digest_chunk)))
        else $error("chunk changed while stalled");

    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_last_chunk) |=> o_empty)
        else $error("result after last chunk");

endmodule

bind sha256_byte_stream_hasher_core sha_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_empty        (o_empty),
    .i_pop          (i_pop),
    .o_digest_chunk (o_digest_chunk),
    .o_chunk_index  (o_chunk_index),
    .o_last_chunk   (o_last_chunk)
);
